[hw/rtl/hit_plane_decluster_majority_assert.svh]
// assertion helpers for the hit plane decluster majority block
`ifndef HIT_PLANE_DECLUSTER_MAJORITY_ASSERT_SVH
`define HIT_PLANE_DECLUSTER_MAJORITY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HPDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HPDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hpdm_pkg.sv]
package hpdm_pkg;

  // port width of every hit pattern
  localparam int HIT_W = 64;

  // default plane geometry
  localparam int PLANE_WIDTH_DEF    = 64;
  localparam int MAX_EDGE_STRIP_DEF = 3;

  // one result word
  typedef struct packed {
    logic [HIT_W-1:0] coincidence_hits;
    logic [HIT_W-1:0] first_layer_left;
    logic [HIT_W-1:0] second_layer_left;
  } hpdm_result_t;

endpackage

[hw/rtl/hpdm_decluster.sv]
module hpdm_decluster
  import hpdm_pkg::*;
#(
  parameter int PLANE_WIDTH    = PLANE_WIDTH_DEF,
  parameter int MAX_EDGE_STRIP = MAX_EDGE_STRIP_DEF
) (
  input  logic [PLANE_WIDTH-1:0] hits,
  output logic [PLANE_WIDTH-1:0] declustered
);

  // run lengths are only needed up to one past the strip limit
  localparam int LOOK = MAX_EDGE_STRIP + 1;
  localparam int CW   = $clog2(LOOK + 1);
  localparam int PW   = PLANE_WIDTH + 2 * LOOK;

  logic [PW-1:0] padded;

  // channels outside the plane read as zero
  assign padded = {{LOOK{1'b0}}, hits, {LOOK{1'b0}}};

  // a set bit with k set bits below and r above in its run survives when
  // both sides are at least the strip limit, or it sits at the run center
  always_comb begin
    logic [CW-1:0] k;
    logic [CW-1:0] r;
    logic          run_lo;
    logic          run_hi;
    logic          centered;
    for (int i = 0; i < PLANE_WIDTH; i++) begin
      k      = '0;
      r      = '0;
      run_lo = 1'b1;
      run_hi = 1'b1;
      for (int j = 1; j <= LOOK; j++) begin
        if (run_lo && padded[i + LOOK - j]) begin
          k = k + 1'b1;
        end else begin
          run_lo = 1'b0;
        end
        if (run_hi && padded[i + LOOK + j]) begin
          r = r + 1'b1;
        end else begin
          run_hi = 1'b0;
        end
      end
      if (k >= r) begin
        centered = (k - r) <= CW'(1);
      end else begin
        centered = (r - k) <= CW'(1);
      end
      declustered[i] = hits[i] &&
                       ((k >= CW'(MAX_EDGE_STRIP) && r >= CW'(MAX_EDGE_STRIP)) || centered);
    end
  end

endmodule

[hw/rtl/hpdm_majority.sv]
module hpdm_majority
  import hpdm_pkg::*;
#(
  parameter int PLANE_WIDTH = PLANE_WIDTH_DEF
) (
  input  logic [PLANE_WIDTH-1:0] layer0,
  input  logic [PLANE_WIDTH-1:0] layer1,
  output hpdm_result_t           result
);

  logic [PLANE_WIDTH-1:0] maj;
  logic [PLANE_WIDTH-1:0] clr;

  // shifts inside the plane width drop anything that leaves the plane
  assign maj = layer0 & (layer1 | (layer1 << 1) | (layer1 >> 1));
  assign clr = maj | (maj << 1) | (maj >> 1);

  assign result.coincidence_hits  = HIT_W'(maj);
  assign result.first_layer_left  = HIT_W'(layer0 & ~clr);
  assign result.second_layer_left = HIT_W'(layer1 & ~clr);

endmodule

[hw/rtl/hit_plane_decluster_majority.sv]
// Two-layer hit declustering and majority for one detector plane. Each
// accepted word carries the hit patterns of both layers; every run of
// adjacent hits is trimmed by up to MAX_EDGE_STRIP channels at each end
// (its one or two center channels always stay), then a layer-0 hit is a
// majority hit when layer 1 has a hit on the same or an adjacent channel.
// The result word holds the majority pattern and both trimmed layers with
// the majority hits and their neighbors cleared. Channels at or above
// PLANE_WIDTH are ignored on input and read as zero on output. One word is
// accepted every cycle while in_stall is low. An input register feeds the
// single combinational trim and majority pass, which lands in the output
// register. A stalled output holds its word and the input register keeps
// accepting until it too is full.
`include "hit_plane_decluster_majority_assert.svh"

module hit_plane_decluster_majority
  import hpdm_pkg::*;
#(
  parameter int PLANE_WIDTH    = PLANE_WIDTH_DEF,
  parameter int MAX_EDGE_STRIP = MAX_EDGE_STRIP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HIT_W-1:0] in_first_layer_hits,
  input  logic [HIT_W-1:0] in_second_layer_hits,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [HIT_W-1:0] out_coincidence_hits,
  output logic [HIT_W-1:0] out_first_layer_left,
  output logic [HIT_W-1:0] out_second_layer_left
);

  // input register stage
  logic                   in_valid_r;
  logic [PLANE_WIDTH-1:0] layer0_r;
  logic [PLANE_WIDTH-1:0] layer1_r;

  // output register stage
  logic         out_valid_r;
  hpdm_result_t result_r;
  hpdm_result_t result_nxt;

  logic [PLANE_WIDTH-1:0] layer0_dc;
  logic [PLANE_WIDTH-1:0] layer1_dc;

  logic out_load;
  logic in_load;

  // output register takes a word when empty or when its word leaves now
  assign out_load = !out_valid_r || !out_stall;
  // input register frees up when empty or when its word moves on
  assign in_stall = in_valid_r && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // payload needs no reset; only bits inside the plane are kept
  always_ff @(posedge clk) begin
    if (in_load) begin
      layer0_r <= in_first_layer_hits[PLANE_WIDTH-1:0];
      layer1_r <= in_second_layer_hits[PLANE_WIDTH-1:0];
    end
  end

  // trim each layer's runs independently
  hpdm_decluster #(
    .PLANE_WIDTH    (PLANE_WIDTH),
    .MAX_EDGE_STRIP (MAX_EDGE_STRIP)
  ) u_decluster0 (
    .hits        (layer0_r),
    .declustered (layer0_dc)
  );

  hpdm_decluster #(
    .PLANE_WIDTH    (PLANE_WIDTH),
    .MAX_EDGE_STRIP (MAX_EDGE_STRIP)
  ) u_decluster1 (
    .hits        (layer1_r),
    .declustered (layer1_dc)
  );

  // majority of the trimmed layers and the leftover hits
  hpdm_majority #(
    .PLANE_WIDTH (PLANE_WIDTH)
  ) u_majority (
    .layer0 (layer0_dc),
    .layer1 (layer1_dc),
    .result (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_coincidence_hits  = result_r.coincidence_hits;
  assign out_first_layer_left  = result_r.first_layer_left;
  assign out_second_layer_left = result_r.second_layer_left;

  // a word in the input register moves to the output when there is room
  `HPDM_ASSERT_NXT(a_word_advances, in_valid_r && out_load, out_valid_r, "word lost between stages")
  // the input only stalls when both registers hold words
  `HPDM_ASSERT_IMP(a_stall_only_full, in_stall, in_valid_r && out_valid_r && out_stall, "needless input stall")
  // majority hits and their neighbors never remain in the leftover layers
  `HPDM_ASSERT_IMP(a_left0_cleared, out_valid_r, ((result_r.coincidence_hits | (result_r.coincidence_hits << 1) | (result_r.coincidence_hits >> 1)) & result_r.first_layer_left) == '0, "layer 0 leftover overlaps majority")
  `HPDM_ASSERT_IMP(a_left1_cleared, out_valid_r, ((result_r.coincidence_hits | (result_r.coincidence_hits << 1) | (result_r.coincidence_hits >> 1)) & result_r.second_layer_left) == '0, "layer 1 leftover overlaps majority")

endmodule
